### hdl/normalised_cross_correlation_unit_macros.svh
// Assertion macros shared by the checker of the correlator.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef NORMALISED_CROSS_CORRELATION_UNIT_MACROS_SVH
`define NORMALISED_CROSS_CORRELATION_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define NCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define NCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/ncc_pkg.sv
// Shared types and constants of the correlator.
// Used by the controller, the datapath, the coefficient unit and the top level.
package ncc_pkg;

  localparam int CFG_W     = 7;
  localparam int IDX_W     = 6;
  localparam int KIND_W    = 2;
  localparam int LEN_RESET = 64;
  localparam int FRAC_BITS = 15;
  localparam int Q_W       = FRAC_BITS + 1;      // root magnitude, up to 1.0
  localparam int DIV_STEPS = 2 * FRAC_BITS;      // fraction bits of the squared ratio
  localparam int QD_W      = DIV_STEPS + 1;
  localparam int COEF_W    = 16;
  localparam int LAG_W     = 20;
  localparam logic [LAG_W-1:0]  LAG_MAX  = {LAG_W{1'b1}};
  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};

  typedef enum logic [KIND_W-1:0] {
    KIND_TMPL    = 2'd0,
    KIND_IMAGE   = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_SPARE   = 2'd3
  } kind_t;

  // what one multiply-accumulate issue does
  typedef enum logic [1:0] {
    OP_DOT = 2'd0,   // template tap times window tap
    OP_TSQ = 2'd1,   // template tap squared
    OP_OLD = 2'd2,   // leaving window sample squared, subtracted
    OP_NEW = 2'd3    // arriving sample squared
  } mac_op_t;

  typedef struct packed {
    logic    cfg_load;
    logic    in_take;
    logic    sweep_init;
    logic    issue;
    mac_op_t op;
    logic    img_commit;
    logic    te_store;
    logic    coef_start;
    logic    result_load;
  } dp_cmd_t;

  typedef struct packed {
    logic tap_last;
    logic mac_busy;
    logic will_fill;
    logic zero_energy;
    logic coef_done;
    logic out_free;
  } dp_stat_t;

endpackage

### hdl/normalised_cross_correlation_unit.sv
// Normalised cross-correlation unit. One item in flight at a time.
// Image sample, window full: the result follows the L-tap MAC sweep, two serial EW-bit products,
// a 31-step divide and a 16-step root, EW = 2*SAMPLE_BITS+log2(TEMPLATE_MAX).
// Template write or length write: an energy sweep over the L taps; restart, spare and filling: no sweep.
// Synchronous active-low reset: template reads as zero, window empty, length 64, no result.
module normalised_cross_correlation_unit import ncc_pkg::*; #(
  parameter int TEMPLATE_MAX = 64,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic [IDX_W-1:0]        in_tap_index,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [COEF_W-1:0] out_coefficient,
  output logic [LAG_W-1:0]        out_lag,
  output logic                    out_zero_energy,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_template_length
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ncc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  ncc_datapath #(
    .TEMPLATE_MAX (TEMPLATE_MAX),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_kind             (in_kind),
    .in_tap_index        (in_tap_index),
    .in_sample           (in_sample),
    .cfg_template_length (cfg_template_length),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_coefficient     (out_coefficient),
    .out_lag             (out_lag),
    .out_zero_energy     (out_zero_energy)
  );

endmodule

### hdl/ncc_ctrl.sv
// Controller of the correlator: sequences sweeps, energy updates and results.
// Depends on ncc_pkg for the command, status and kind types.
module ncc_ctrl import ncc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [KIND_W-1:0] in_kind,
  input  logic     cfg_valid,
  input  dp_stat_t stat,
  output logic     in_stall,
  output logic     cfg_ready,
  output dp_cmd_t  cmd
);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b000000000001,
    ST_TE_INIT   = 12'b000000000010,
    ST_TE_RUN    = 12'b000000000100,
    ST_TE_WAIT   = 12'b000000001000,
    ST_IMG_OLD   = 12'b000000010000,
    ST_IMG_NEW   = 12'b000000100000,
    ST_IMG_WAIT  = 12'b000001000000,
    ST_DOT_INIT  = 12'b000010000000,
    ST_DOT_RUN   = 12'b000100000000,
    ST_DOT_WAIT  = 12'b001000000000,
    ST_COEF_WAIT = 12'b010000000000,
    ST_RESULT    = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = OP_DOT;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;      // a register write wins
        if (cfg_valid) begin
          cmd.cfg_load = 1'b1;
          state_nxt    = ST_TE_INIT;
        end else if (in_valid) begin
          cmd.in_take = 1'b1;
          case (kind_t'(in_kind))
            KIND_TMPL:  state_nxt = ST_TE_INIT;
            KIND_IMAGE: state_nxt = ST_IMG_OLD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TE_INIT: begin
        cmd.sweep_init = 1'b1;
        state_nxt      = ST_TE_RUN;
      end
      ST_TE_RUN: begin
        cmd.issue = 1'b1;
        cmd.op    = OP_TSQ;
        if (stat.tap_last) state_nxt = ST_TE_WAIT;
      end
      ST_TE_WAIT: begin
        if (!stat.mac_busy) begin
          cmd.te_store = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_IMG_OLD: begin
        cmd.issue = 1'b1;
        cmd.op    = OP_OLD;
        state_nxt = ST_IMG_NEW;
      end
      ST_IMG_NEW: begin
        cmd.issue = 1'b1;
        cmd.op    = OP_NEW;
        state_nxt = ST_IMG_WAIT;
      end
      ST_IMG_WAIT: begin
        if (!stat.mac_busy) begin
          cmd.img_commit = 1'b1;
          state_nxt      = stat.will_fill ? ST_DOT_INIT : ST_IDLE;
        end
      end
      ST_DOT_INIT: begin
        cmd.sweep_init = 1'b1;
        state_nxt      = ST_DOT_RUN;
      end
      ST_DOT_RUN: begin
        cmd.issue = 1'b1;
        cmd.op    = OP_DOT;
        if (stat.tap_last) state_nxt = ST_DOT_WAIT;
      end
      ST_DOT_WAIT: begin
        if (!stat.mac_busy) begin
          if (stat.zero_energy) begin
            state_nxt = ST_RESULT;
          end else begin
            cmd.coef_start = 1'b1;
            state_nxt      = ST_COEF_WAIT;
          end
        end
      end
      ST_COEF_WAIT: begin
        if (stat.coef_done) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.result_load = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### hdl/ncc_coef.sv
// Iterative coefficient unit: serial products, restoring divide, bitwise root.
// Depends on ncc_pkg for the fraction and result widths.
module ncc_coef import ncc_pkg::*; #(
  parameter int EW = 38
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [EW-1:0] dot_mag,
  input  logic [EW-1:0] te,
  input  logic [EW-1:0] we,
  output logic          done,
  output logic [Q_W-1:0] q
);

  localparam int PW  = 2 * EW;
  localparam int RW  = PW + 1;
  localparam int CW  = $clog2(((EW > DIV_STEPS) ? EW : DIV_STEPS) + 1);
  localparam int SHW = $clog2(Q_W);

  typedef enum logic [5:0] {
    CF_IDLE = 6'b000001,
    CF_MULP = 6'b000010,
    CF_MULS = 6'b000100,
    CF_DIV0 = 6'b001000,
    CF_DIV  = 6'b010000,
    CF_SQRT = 6'b100000
  } coef_state_t;

  coef_state_t     state_r;
  logic [CW-1:0]   cnt_r;
  logic [PW-1:0]   mcand_r, pacc_r, p_r;
  logic [EW-1:0]   mplier_r;
  logic [RW-1:0]   rem_r;
  logic [QD_W-1:0] qd_r;
  logic [Q_W-1:0]  qs_r;
  logic            done_r;

  logic [PW-1:0]    pacc_step;
  logic [RW-1:0]    rem_sh, p_ext;
  logic [SHW-1:0]   sq_sh;
  logic [Q_W-1:0]   sq_try;
  logic [2*Q_W-1:0] sq_sq;
  logic             sq_fit;

  // one shift-add step, one divide step, one root trial
  always_comb begin
    pacc_step = mplier_r[0] ? pacc_r + mcand_r : pacc_r;
    p_ext     = {1'b0, p_r};
    rem_sh    = {rem_r[RW-2:0], 1'b0};
    sq_sh     = SHW'(Q_W - 1) - cnt_r[SHW-1:0];
    sq_try    = qs_r | (Q_W'(1) << sq_sh);
    sq_sq     = sq_try * sq_try;
    sq_fit    = sq_sq <= (2*Q_W)'(qd_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CF_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        CF_IDLE: begin
          if (start) begin
            mcand_r  <= PW'(te);
            mplier_r <= we;
            pacc_r   <= '0;
            cnt_r    <= '0;
            state_r  <= CF_MULP;
          end
        end
        CF_MULP: begin
          if (cnt_r == CW'(EW - 1)) begin
            p_r      <= pacc_step;
            mcand_r  <= PW'(dot_mag);
            mplier_r <= dot_mag;
            pacc_r   <= '0;
            cnt_r    <= '0;
            state_r  <= CF_MULS;
          end else begin
            pacc_r   <= pacc_step;
            mcand_r  <= mcand_r << 1;
            mplier_r <= mplier_r >> 1;
            cnt_r    <= cnt_r + 1'b1;
          end
        end
        CF_MULS: begin
          pacc_r   <= pacc_step;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == CW'(EW - 1)) begin
            rem_r   <= RW'(pacc_step);
            state_r <= CF_DIV0;
          end
        end
        CF_DIV0: begin
          // integer part of the squared ratio, 0 or 1
          if (rem_r >= p_ext) begin
            rem_r <= rem_r - p_ext;
            qd_r  <= QD_W'(1);
          end else begin
            qd_r  <= '0;
          end
          cnt_r   <= '0;
          state_r <= CF_DIV;
        end
        CF_DIV: begin
          if (rem_sh >= p_ext) begin
            rem_r <= rem_sh - p_ext;
            qd_r  <= {qd_r[QD_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            qd_r  <= {qd_r[QD_W-2:0], 1'b0};
          end
          if (cnt_r == CW'(DIV_STEPS - 1)) begin
            cnt_r   <= '0;
            qs_r    <= '0;
            state_r <= CF_SQRT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        CF_SQRT: begin
          if (sq_fit) qs_r <= sq_try;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(Q_W - 1)) begin
            done_r  <= 1'b1;
            state_r <= CF_IDLE;
          end
        end
        default: state_r <= CF_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign q    = qs_r;

endmodule

### hdl/ncc_datapath.sv
// Datapath: template and window memories, shared multiply-accumulate,
// energies, counters and the result register. Uses ncc_pkg and ncc_coef.
module ncc_datapath import ncc_pkg::*; #(
  parameter int TEMPLATE_MAX = 64,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic [IDX_W-1:0]        in_tap_index,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [CFG_W-1:0]        cfg_template_length,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic signed [COEF_W-1:0] out_coefficient,
  output logic [LAG_W-1:0]        out_lag,
  output logic                    out_zero_energy
);

  localparam int IW    = $clog2(TEMPLATE_MAX);
  localparam int LW    = $clog2(TEMPLATE_MAX + 1);
  localparam int EW    = 2 * SAMPLE_BITS + IW;
  localparam int AW    = EW + 1;
  localparam int PRW   = 2 * SAMPLE_BITS;
  localparam int CMP_W = (LW > CFG_W) ? LW : CFG_W;
  localparam int XW    = IW + 2;

  function automatic logic [LW-1:0] clamp_len(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] ve;
    begin
      ve = CMP_W'(v);
      if (ve == '0) return LW'(1);
      else if (ve > CMP_W'(TEMPLATE_MAX)) return LW'(TEMPLATE_MAX);
      else return LW'(ve);
    end
  endfunction

  // memories and tap valid bits
  logic [SAMPLE_BITS-1:0] tmem [TEMPLATE_MAX];
  logic [SAMPLE_BITS-1:0] wmem [TEMPLATE_MAX];
  logic [TEMPLATE_MAX-1:0] tvalid_r;

  logic [LW-1:0]  leff_r, fill_r;
  logic [IW-1:0]  wptr_r, tap_r, wrd_r;
  logic [EW-1:0]  te_r, we_r;
  logic [LAG_W-1:0] lag_r;
  logic signed [SAMPLE_BITS-1:0] s_r;
  logic signed [AW-1:0] acc_r;

  // stage registers of the multiply-accumulate
  logic [SAMPLE_BITS-1:0] trd_r, wd_r;
  logic                   tv_r;
  logic                   st1_valid_r, st1_full_r, st2_valid_r, st2_sub_r;
  mac_op_t                st1_op_r;
  logic signed [PRW-1:0]  prod_r;

  logic                   out_valid_r, out_zero_r;
  logic [COEF_W-1:0]      out_coef_r;
  logic [LAG_W-1:0]       out_lag_r;

  logic                   take_tmpl, take_img, take_rst, idx_ok;
  logic [IW-1:0]          widx, win_start, tap_inc, wrd_inc, wptr_inc;
  logic [XW-1:0]          wp_x, l_x;
  logic signed [SAMPLE_BITS-1:0] op_a, op_b, tdat;
  logic                   neg, zero_e, full;
  logic [AW-1:0]          mag;
  logic                   coef_done;
  logic [Q_W-1:0]         coef_q;
  logic [COEF_W-1:0]      coef_val;

  always_comb begin
    take_tmpl = cmd.in_take && (kind_t'(in_kind) == KIND_TMPL);
    take_img  = cmd.in_take && (kind_t'(in_kind) == KIND_IMAGE);
    take_rst  = cmd.in_take && (kind_t'(in_kind) == KIND_RESTART);
    idx_ok    = 32'(in_tap_index) < 32'(TEMPLATE_MAX);
    widx      = IW'(in_tap_index);
    full      = fill_r == leff_r;
    // oldest window slot: write pointer minus length, wrapped
    wp_x      = XW'(wptr_r);
    l_x       = XW'(leff_r);
    if (wp_x >= l_x) win_start = IW'(wp_x - l_x);
    else             win_start = IW'(wp_x + XW'(TEMPLATE_MAX) - l_x);
    tap_inc   = (tap_r  == IW'(TEMPLATE_MAX - 1)) ? '0 : tap_r  + 1'b1;
    wrd_inc   = (wrd_r  == IW'(TEMPLATE_MAX - 1)) ? '0 : wrd_r  + 1'b1;
    wptr_inc  = (wptr_r == IW'(TEMPLATE_MAX - 1)) ? '0 : wptr_r + 1'b1;
  end

  // template memory
  always_ff @(posedge clk) begin
    if (take_tmpl && idx_ok) tmem[widx] <= in_sample;
    trd_r <= tmem[tap_r];
  end

  // window memory, circular
  always_ff @(posedge clk) begin
    if (cmd.img_commit) wmem[wptr_r] <= s_r;
    wd_r <= wmem[wrd_r];
  end

  // control state: lengths, pointers, energies, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= '0;
      tv_r     <= 1'b0;
      leff_r   <= clamp_len(CFG_W'(LEN_RESET));
      fill_r   <= '0;
      wptr_r   <= '0;
      tap_r    <= '0;
      wrd_r    <= '0;
      te_r     <= '0;
      we_r     <= '0;
      lag_r    <= '0;
      st1_valid_r <= 1'b0;
      st2_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tv_r <= tvalid_r[tap_r];
      if (take_tmpl && idx_ok) tvalid_r[widx] <= 1'b1;
      if (cmd.cfg_load) leff_r <= clamp_len(cfg_template_length);
      if (cmd.cfg_load || take_rst) begin
        fill_r <= '0;
        we_r   <= '0;
        lag_r  <= '0;
      end
      if (take_img) wrd_r <= win_start;
      if (cmd.sweep_init) begin
        tap_r <= '0;
        wrd_r <= win_start;
      end
      if (cmd.issue) begin
        tap_r <= tap_inc;
        wrd_r <= wrd_inc;
      end
      if (cmd.img_commit) begin
        we_r   <= acc_r[EW-1:0];
        wptr_r <= wptr_inc;
        if (!full) fill_r <= fill_r + 1'b1;
      end
      if (cmd.te_store) te_r <= acc_r[EW-1:0];
      st1_valid_r <= cmd.issue;
      st2_valid_r <= st1_valid_r;
      if (cmd.result_load) begin
        out_valid_r <= 1'b1;
        if (lag_r != LAG_MAX) lag_r <= lag_r + 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    tdat = tv_r ? signed'(trd_r) : '0;
    case (st1_op_r)
      OP_DOT: begin op_a = tdat;          op_b = signed'(wd_r); end
      OP_TSQ: begin op_a = tdat;          op_b = tdat;          end
      OP_OLD: begin
        op_a = st1_full_r ? signed'(wd_r) : '0;
        op_b = op_a;
      end
      OP_NEW: begin op_a = s_r;           op_b = s_r;           end
      default: begin op_a = '0;           op_b = '0;            end
    endcase
  end

  // payload pipeline: sample, stage tags, product, accumulator
  always_ff @(posedge clk) begin
    if (take_img) s_r <= in_sample;
    st1_op_r   <= cmd.op;
    st1_full_r <= full;
    prod_r     <= op_a * op_b;
    st2_sub_r  <= st1_op_r == OP_OLD;
    if (take_img) begin
      acc_r <= signed'({1'b0, we_r});
    end else if (cmd.sweep_init) begin
      acc_r <= '0;
    end else if (st2_valid_r) begin
      if (st2_sub_r) acc_r <= acc_r - AW'(prod_r);
      else           acc_r <= acc_r + AW'(prod_r);
    end
  end

  // coefficient from dot magnitude and energies
  always_comb begin
    neg    = acc_r[AW-1];
    mag    = neg ? AW'(-acc_r) : AW'(acc_r);
    zero_e = (te_r == '0) || (we_r == '0);
    if (zero_e)                    coef_val = '0;
    else if (neg)                  coef_val = COEF_W'(0) - COEF_W'(coef_q);
    else if (COEF_W'(coef_q) > COEF_MAX) coef_val = COEF_MAX;
    else                           coef_val = COEF_W'(coef_q);
  end

  ncc_coef #(.EW(EW)) u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.coef_start),
    .dot_mag (mag[EW-1:0]),
    .te      (te_r),
    .we      (we_r),
    .done    (coef_done),
    .q       (coef_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_coef_r <= coef_val;
      out_lag_r  <= lag_r;
      out_zero_r <= zero_e;
    end
  end

  always_comb begin
    stat.tap_last    = LW'(tap_r) == leff_r - 1'b1;
    stat.mac_busy    = st1_valid_r || st2_valid_r;
    stat.will_fill   = full || ((fill_r + 1'b1) == leff_r);
    stat.zero_energy = zero_e;
    stat.coef_done   = coef_done;
    stat.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = signed'(out_coef_r);
  assign out_lag         = out_lag_r;
  assign out_zero_energy = out_zero_r;

endmodule

### hdl/ncc_checker.sv
// Port-level checker of the correlator, bound to the top level.
// Depends on ncc_pkg and the assertion macros header.
`include "normalised_cross_correlation_unit_macros.svh"

module ncc_checker import ncc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [COEF_W-1:0]       out_coefficient,
  input logic [LAG_W-1:0]        out_lag,
  input logic                    out_zero_energy,
  input logic                    cfg_valid,
  input logic                    cfg_ready
);

  // a stalled result word holds
  `NCC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_coefficient) && $stable(out_lag), "result word changed under stall")

  // zero energy gives a zero coefficient
  `NCC_ASSERT_IMP(a_zero_coef, clk, rst_n, out_valid && out_zero_energy, out_coefficient == '0, "zero energy with nonzero coefficient")

  // a register write blocks input in the same cycle
  `NCC_ASSERT_IMP(a_cfg_first, clk, rst_n, cfg_valid && cfg_ready, in_stall, "input taken alongside register write")

  // a length write starts the energy sweep
  `NCC_ASSERT_NXT(a_cfg_busy, clk, rst_n, cfg_valid && cfg_ready, !cfg_ready, "register port ready during energy sweep")

endmodule

bind normalised_cross_correlation_unit ncc_checker u_ncc_checker (.*);
